/* rtl/spi_handshake_transfer_master_unit_assert.svh */
// assertion macros for the spi handshake transfer master
// used at the end of the top level, expects clk and arst_n in scope
`ifndef SPI_HANDSHAKE_TRANSFER_MASTER_UNIT_ASSERT_SVH
`define SPI_HANDSHAKE_TRANSFER_MASTER_UNIT_ASSERT_SVH

// checked only while out of reset
`define SHTM_ASSERT_RUN(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge
`define SHTM_ASSERT_ALL(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/spi_hs_pkg.sv */
// package for the spi handshake transfer master: word types, op and phase codes,
// protocol constants; no dependencies
`timescale 1ns / 1ps

package spi_hs_pkg;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] length;
		logic        dir_level;
		logic        data_pending;
		logic [7:0]  rx_byte;
		logic [7:0]  payload_byte;
	} spi_hs_in_t;

	typedef struct packed {
		logic        chip_select;
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        payload_request;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic        done_res;
		logic [2:0]  status;
		logic [7:0]  device_code;
		logic [15:0] granted_length;
	} spi_hs_out_t;

	localparam int LIMIT_W = 20;
	localparam int WAIT_W  = LIMIT_W + 1;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100;
	localparam logic               REG_TIMEOUT = 1'b0;

	localparam logic [2:0] OP_START_WR = 3'd0;
	localparam logic [2:0] OP_START_RD = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_SPI_BYTE = 3'd3;
	localparam logic [2:0] OP_PAYLOAD  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TIMEOUT1  = 3'd1;
	localparam logic [2:0] ST_TIMEOUT2  = 3'd2;
	localparam logic [2:0] ST_TIMEOUT3  = 3'd3;
	localparam logic [2:0] ST_NO_ACK    = 3'd4;
	localparam logic [2:0] ST_NOT_READY = 3'd5;
	localparam logic [2:0] ST_BUSY      = 3'd6;

	localparam logic [7:0] TAG_PRE = 8'h55;
	localparam logic [7:0] TAG_WR  = 8'h80;
	localparam logic [7:0] TAG_RD  = 8'h00;
	localparam logic [7:0] TAG_ACK = 8'hBE;
	localparam logic [7:0] TAG_DMY = 8'hFF;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_WAIT1 = 4'd1;
	localparam logic [3:0] PH_HDR   = 4'd2;
	localparam logic [3:0] PH_WAIT2 = 4'd3;
	localparam logic [3:0] PH_ACK   = 4'd4;
	localparam logic [3:0] PH_STAT  = 4'd5;
	localparam logic [3:0] PH_LENH  = 4'd6;
	localparam logic [3:0] PH_LENL  = 4'd7;
	localparam logic [3:0] PH_RDATA = 4'd8;
	localparam logic [3:0] PH_WAIT3 = 4'd9;
	localparam logic [3:0] PH_WREQ  = 4'd10;
	localparam logic [3:0] PH_WSENT = 4'd11;

endpackage

/* rtl/spi_hs_cfg.sv */
// apb register block holding the direction wait limit
// depends on spi_hs_pkg
`timescale 1ns / 1ps

module spi_hs_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spi_hs_pkg::PADDR_W-1:0]    paddr,
	input  logic [spi_hs_pkg::PDATA_W-1:0]    pwdata,
	output logic [spi_hs_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [spi_hs_pkg::LIMIT_W-1:0]    timeout_limit
);
	import spi_hs_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               sel_timeout;

	assign sel_timeout = (paddr[PADDR_W-1] == REG_TIMEOUT);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_timeout) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_timeout) begin
			prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_q};
		end
	end

	assign timeout_limit = limit_q;

endmodule

/* rtl/spi_hs_seq.sv */
// transfer sequencer: phase state, counters and the per-word result logic
// depends on spi_hs_pkg
`timescale 1ns / 1ps

module spi_hs_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  spi_hs_pkg::spi_hs_in_t         item,
	input  logic [spi_hs_pkg::LIMIT_W-1:0] timeout_limit,
	output logic                           res_ok,
	output spi_hs_pkg::spi_hs_out_t        res
);
	import spi_hs_pkg::*;

	logic [3:0]        phase_q, phase_d;
	logic              is_read_q, is_read_d;
	logic [1:0]        hdr_q, hdr_d;
	logic [15:0]       req_len_q, req_len_d;
	logic [15:0]       grant_q, grant_d;
	logic [15:0]       count_q, count_d;
	logic [WAIT_W-1:0] wait_q, wait_d;

	logic              cs_now;
	logic              wait_over;
	logic [15:0]       count_inc;
	logic [15:0]       grant_full;
	logic [WAIT_W-1:0] wait_inc;

	function automatic logic [7:0] header_byte(input logic [1:0] idx, input logic rd,
		input logic [15:0] len);
		logic [7:0] b;
		case (idx)
			2'd0: b = TAG_PRE;
			2'd1: b = rd ? TAG_RD : TAG_WR;
			2'd2: b = len[15:8];
			default: b = len[7:0];
		endcase
		return b;
	endfunction

	function automatic logic cs_active(input logic [3:0] ph);
		return (ph == PH_HDR) || (ph == PH_ACK) || (ph == PH_STAT) || (ph == PH_LENH) ||
			(ph == PH_LENL) || (ph == PH_RDATA) || (ph == PH_WREQ) || (ph == PH_WSENT);
	endfunction

	assign cs_now     = cs_active(phase_q);
	assign wait_over  = (wait_q > {1'b0, timeout_limit});
	assign count_inc  = count_q + 16'd1;
	assign grant_full = {grant_q[15:8], item.rx_byte};
	assign wait_inc   = wait_q + WAIT_W'(1);

	always_comb begin
		phase_d   = phase_q;
		is_read_d = is_read_q;
		hdr_d     = hdr_q;
		req_len_d = req_len_q;
		grant_d   = grant_q;
		count_d   = count_q;
		wait_d    = wait_q;
		res_ok    = 1'b0;
		res       = '0;
		res.chip_select = cs_now;

		case (item.op)
			OP_START_WR, OP_START_RD: begin
				res_ok = 1'b0;
				if (phase_q != PH_IDLE) begin
					res_ok = 1'b1;
					res.done_res = 1'b1;
					res.status = ST_BUSY;
				end else begin
					is_read_d = (item.op == OP_START_RD);
					req_len_d = item.length;
					grant_d   = '0;
					count_d   = '0;
					hdr_d     = '0;
					wait_d    = '0;
					if ((item.op == OP_START_RD) && !item.data_pending) begin
						res_ok = 1'b1;
						res.done_res = 1'b1;
						res.status = ST_OK;
					end else begin
						phase_d = PH_WAIT1;
					end
				end
			end
			OP_TICK: begin
				case (phase_q)
					PH_WAIT1: begin
						if (!item.dir_level) begin
							if (wait_over) begin
								res_ok = 1'b1;
								phase_d = PH_IDLE;
								res.chip_select = 1'b0;
								res.done_res = 1'b1;
								res.status = ST_TIMEOUT1;
							end else begin
								wait_d = wait_inc;
							end
						end else begin
							res_ok = 1'b1;
							phase_d = PH_HDR;
							hdr_d = '0;
							res.chip_select = 1'b1;
							res.send_valid = 1'b1;
							res.send_byte = TAG_PRE;
						end
					end
					PH_WAIT2: begin
						if (item.dir_level) begin
							if (wait_over) begin
								res_ok = 1'b1;
								phase_d = PH_IDLE;
								res.chip_select = 1'b0;
								res.done_res = 1'b1;
								res.status = ST_TIMEOUT2;
							end else begin
								wait_d = wait_inc;
							end
						end else begin
							res_ok = 1'b1;
							phase_d = PH_ACK;
							res.chip_select = 1'b1;
							res.send_valid = 1'b1;
							res.send_byte = TAG_DMY;
						end
					end
					PH_WAIT3: begin
						if (!item.dir_level) begin
							if (wait_over) begin
								res_ok = 1'b1;
								phase_d = PH_IDLE;
								res.chip_select = 1'b0;
								res.done_res = 1'b1;
								res.status = ST_TIMEOUT3;
							end else begin
								wait_d = wait_inc;
							end
						end else if (grant_q == '0) begin
							res_ok = 1'b1;
							phase_d = PH_IDLE;
							res.chip_select = 1'b0;
							res.done_res = 1'b1;
						end else begin
							res_ok = 1'b1;
							phase_d = PH_WREQ;
							count_d = '0;
							res.chip_select = 1'b1;
							res.payload_request = 1'b1;
						end
					end
					default: begin
						res_ok = 1'b0;
					end
				endcase
			end
			OP_SPI_BYTE: begin
				case (phase_q)
					PH_HDR: begin
						res_ok = 1'b1;
						if (hdr_q != 2'd3) begin
							hdr_d = hdr_q + 2'd1;
							res.send_valid = 1'b1;
							res.send_byte = header_byte(hdr_q + 2'd1, is_read_q, req_len_q);
						end else begin
							hdr_d = '0;
							phase_d = PH_WAIT2;
							wait_d = '0;
							res.chip_select = 1'b0;
						end
					end
					PH_ACK: begin
						res_ok = 1'b1;
						if (item.rx_byte != TAG_ACK) begin
							phase_d = PH_IDLE;
							res.chip_select = 1'b0;
							res.done_res = 1'b1;
							res.status = ST_NO_ACK;
						end else begin
							phase_d = PH_STAT;
							res.send_valid = 1'b1;
							res.send_byte = TAG_DMY;
						end
					end
					PH_STAT: begin
						res_ok = 1'b1;
						if (item.rx_byte != 8'd0) begin
							phase_d = PH_IDLE;
							res.chip_select = 1'b0;
							res.done_res = 1'b1;
							res.status = ST_NOT_READY;
							res.device_code = item.rx_byte;
						end else begin
							phase_d = PH_LENH;
							res.send_valid = 1'b1;
							res.send_byte = TAG_DMY;
						end
					end
					PH_LENH: begin
						res_ok = 1'b1;
						grant_d = {item.rx_byte, 8'd0};
						phase_d = PH_LENL;
						res.send_valid = 1'b1;
						res.send_byte = TAG_DMY;
					end
					PH_LENL: begin
						res_ok = 1'b1;
						grant_d = grant_full;
						count_d = '0;
						if (is_read_q) begin
							if (grant_full == '0) begin
								phase_d = PH_IDLE;
								res.chip_select = 1'b0;
								res.done_res = 1'b1;
							end else begin
								phase_d = PH_RDATA;
								res.send_valid = 1'b1;
								res.send_byte = TAG_DMY;
							end
						end else begin
							phase_d = PH_WAIT3;
							wait_d = '0;
							res.chip_select = 1'b0;
						end
					end
					PH_RDATA: begin
						res_ok = 1'b1;
						count_d = count_inc;
						res.read_valid = 1'b1;
						res.read_byte = item.rx_byte;
						if (count_inc == grant_q) begin
							phase_d = PH_IDLE;
							res.chip_select = 1'b0;
							res.done_res = 1'b1;
							res.granted_length = grant_q;
						end else begin
							res.send_valid = 1'b1;
							res.send_byte = TAG_DMY;
						end
					end
					PH_WSENT: begin
						res_ok = 1'b1;
						count_d = count_inc;
						if (count_inc == grant_q) begin
							phase_d = PH_IDLE;
							res.chip_select = 1'b0;
							res.done_res = 1'b1;
							res.granted_length = grant_q;
						end else begin
							phase_d = PH_WREQ;
							res.payload_request = 1'b1;
						end
					end
					default: begin
						res_ok = 1'b0;
					end
				endcase
			end
			OP_PAYLOAD: begin
				if (phase_q == PH_WREQ) begin
					res_ok = 1'b1;
					phase_d = PH_WSENT;
					res.send_valid = 1'b1;
					res.send_byte = item.payload_byte;
				end
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			is_read_q <= 1'b0;
			hdr_q     <= '0;
			req_len_q <= '0;
			grant_q   <= '0;
			count_q   <= '0;
			wait_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			is_read_q <= is_read_d;
			hdr_q     <= hdr_d;
			req_len_q <= req_len_d;
			grant_q   <= grant_d;
			count_q   <= count_d;
			wait_q    <= wait_d;
		end
	end

endmodule

/* rtl/spi_handshake_transfer_master_unit.sv */
// top level of the spi handshake transfer master: input register, sequencer,
// result register and apb register block; depends on spi_hs_pkg, spi_hs_cfg, spi_hs_seq
//
// channel  | words             | flow control
// item     | spi_hs_in_t       | item_valid / item_stall
// res      | spi_hs_out_t      | res_valid / res_stall
// apb      | timeout_limit reg | psel / penable, pready tied high
//
// a word is held in the input register and its result in the result register
// one word per cycle while res_stall is low; phase update and one compare set the path
// words that give no result are consumed without touching the result register
// a full result register under res_stall holds the input register and raises item_stall
// reset returns to idle with a wait limit of 100
`timescale 1ns / 1ps

module spi_handshake_transfer_master_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  spi_hs_pkg::spi_hs_in_t         item,
	output logic                           res_valid,
	input  logic                           res_stall,
	output spi_hs_pkg::spi_hs_out_t        res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [spi_hs_pkg::PADDR_W-1:0] paddr,
	input  logic [spi_hs_pkg::PDATA_W-1:0] pwdata,
	output logic [spi_hs_pkg::PDATA_W-1:0] prdata,
	output logic                           pready
);
	import spi_hs_pkg::*;

	`include "spi_handshake_transfer_master_unit_assert.svh"

	spi_hs_in_t         item_s1;
	logic               valid_s1;
	spi_hs_out_t        res_q;
	logic               res_valid_q;
	spi_hs_out_t        seq_res;
	logic               seq_ok;
	logic               out_free;
	logic               fire;
	logic [LIMIT_W-1:0] timeout_limit;

	assign out_free   = !res_valid_q || !res_stall;
	assign fire       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	spi_hs_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_limit (timeout_limit)
	);

	spi_hs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.timeout_limit (timeout_limit),
		.res_ok        (seq_ok),
		.res           (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && seq_ok) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && seq_ok) begin
			res_q <= seq_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SHTM_ASSERT_RUN(a_send_not_done, res_valid |-> !(res.send_valid && res.done_res), "send and done in one word")
	`SHTM_ASSERT_RUN(a_req_under_cs, (res_valid && res.payload_request) |-> res.chip_select, "payload request without chip select")
	`SHTM_ASSERT_RUN(a_fail_released, (res_valid && res.done_res && res.status != ST_OK && res.status != ST_BUSY) |-> (!res.chip_select && res.granted_length == '0), "failure left select or length")
	`SHTM_ASSERT_ALL(a_no_stall_empty, item_stall |-> valid_s1, "stall with empty input register")

endmodule

/* dv/spi_hs_xfer_checker.sv */
// checker for the spi handshake transfer master: watches the word, result and apb
// channels, predicts each result and compares it; depends on spi_hs_pkg
`timescale 1ns / 1ps

module spi_hs_xfer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  spi_hs_pkg::spi_hs_in_t         item,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  spi_hs_pkg::spi_hs_out_t        res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [spi_hs_pkg::PADDR_W-1:0] paddr,
	input  logic [spi_hs_pkg::PDATA_W-1:0] pwdata,
	output int                             failures,
	output int                             outstanding
);
	import spi_hs_pkg::*;

	logic [LIMIT_W-1:0] wait_limit;
	logic [3:0]         phase;
	logic               is_rd;
	logic [2:0]         hdr_idx;
	logic [15:0]        req_len;
	logic [15:0]        grant_len;
	logic [15:0]        byte_cnt;
	logic [WAIT_W-1:0]  miss_cnt;

	spi_hs_out_t awaited_res[$];

	function automatic logic select_on();
		return phase inside {PH_HDR, PH_ACK, PH_STAT, PH_LENH, PH_LENL, PH_RDATA,
			PH_WREQ, PH_WSENT};
	endfunction

	function automatic void emit(inout spi_hs_out_t r, input logic [7:0] b);
		r.chip_select = select_on();
		r.send_valid  = 1'b1;
		r.send_byte   = b;
	endfunction

	function automatic void conclude(inout spi_hs_out_t r, input logic [2:0] st,
			input logic [7:0] code, input logic [15:0] glen);
		phase            = PH_IDLE;
		r.chip_select    = 1'b0;
		r.done_res       = 1'b1;
		r.status         = st;
		r.device_code    = code;
		r.granted_length = glen;
	endfunction

	// one sample against the awaited direction: true once the wait has run out
	function automatic bit wait_expired();
		if (miss_cnt > WAIT_W'(wait_limit))
			return 1'b1;
		miss_cnt = miss_cnt + WAIT_W'(1);
		return 1'b0;
	endfunction

	function automatic logic [7:0] header_byte(input logic [2:0] i);
		case (i)
			3'd0: return TAG_PRE;
			3'd1: return is_rd ? TAG_RD : TAG_WR;
			3'd2: return req_len[15:8];
			default: return req_len[7:0];
		endcase
	endfunction

	// advances the sequencer by one word; returns 1 when the word yields a result
	function automatic bit sequence_step(input spi_hs_in_t w, output spi_hs_out_t r);
		r = '0;
		r.chip_select = select_on();
		case (w.op)
			OP_START_WR, OP_START_RD: begin
				if (phase != PH_IDLE) begin
					r.done_res = 1'b1;
					r.status   = ST_BUSY;
					return 1'b1;
				end
				is_rd     = (w.op == OP_START_RD);
				req_len   = w.length;
				grant_len = '0;
				byte_cnt  = '0;
				hdr_idx   = '0;
				miss_cnt  = '0;
				if (is_rd && !w.data_pending) begin
					conclude(r, ST_OK, 8'h00, 16'h0000);
					return 1'b1;
				end
				phase = PH_WAIT1;
				return 1'b0;
			end
			OP_TICK: begin
				case (phase)
					PH_WAIT1: begin
						if (!w.dir_level) begin
							if (!wait_expired())
								return 1'b0;
							conclude(r, ST_TIMEOUT1, 8'h00, 16'h0000);
							return 1'b1;
						end
						phase   = PH_HDR;
						hdr_idx = '0;
						emit(r, header_byte(3'd0));
						return 1'b1;
					end
					PH_WAIT2: begin
						if (w.dir_level) begin
							if (!wait_expired())
								return 1'b0;
							conclude(r, ST_TIMEOUT2, 8'h00, 16'h0000);
							return 1'b1;
						end
						phase = PH_ACK;
						emit(r, TAG_DMY);
						return 1'b1;
					end
					PH_WAIT3: begin
						if (!w.dir_level) begin
							if (!wait_expired())
								return 1'b0;
							conclude(r, ST_TIMEOUT3, 8'h00, 16'h0000);
							return 1'b1;
						end
						if (grant_len == 16'h0000) begin
							conclude(r, ST_OK, 8'h00, 16'h0000);
							return 1'b1;
						end
						phase             = PH_WREQ;
						byte_cnt          = '0;
						r.chip_select     = 1'b1;
						r.payload_request = 1'b1;
						return 1'b1;
					end
					default: return 1'b0;
				endcase
			end
			OP_SPI_BYTE: begin
				case (phase)
					PH_HDR: begin
						hdr_idx = hdr_idx + 3'd1;
						if (hdr_idx < 3'd4) begin
							emit(r, header_byte(hdr_idx));
							return 1'b1;
						end
						hdr_idx       = '0;
						phase         = PH_WAIT2;
						miss_cnt      = '0;
						r.chip_select = 1'b0;
						return 1'b1;
					end
					PH_ACK: begin
						if (w.rx_byte != TAG_ACK) begin
							conclude(r, ST_NO_ACK, 8'h00, 16'h0000);
							return 1'b1;
						end
						phase = PH_STAT;
						emit(r, TAG_DMY);
						return 1'b1;
					end
					PH_STAT: begin
						if (w.rx_byte != 8'h00) begin
							conclude(r, ST_NOT_READY, w.rx_byte, 16'h0000);
							return 1'b1;
						end
						phase = PH_LENH;
						emit(r, TAG_DMY);
						return 1'b1;
					end
					PH_LENH: begin
						grant_len = {w.rx_byte, 8'h00};
						phase     = PH_LENL;
						emit(r, TAG_DMY);
						return 1'b1;
					end
					PH_LENL: begin
						grant_len = grant_len | {8'h00, w.rx_byte};
						byte_cnt  = '0;
						if (is_rd) begin
							if (grant_len == 16'h0000) begin
								conclude(r, ST_OK, 8'h00, 16'h0000);
								return 1'b1;
							end
							phase = PH_RDATA;
							emit(r, TAG_DMY);
							return 1'b1;
						end
						phase         = PH_WAIT3;
						miss_cnt      = '0;
						r.chip_select = 1'b0;
						return 1'b1;
					end
					PH_RDATA: begin
						r.read_valid = 1'b1;
						r.read_byte  = w.rx_byte;
						byte_cnt     = byte_cnt + 16'd1;
						if (byte_cnt == grant_len) begin
							conclude(r, ST_OK, 8'h00, grant_len);
							return 1'b1;
						end
						emit(r, TAG_DMY);
						return 1'b1;
					end
					PH_WSENT: begin
						byte_cnt = byte_cnt + 16'd1;
						if (byte_cnt == grant_len) begin
							conclude(r, ST_OK, 8'h00, grant_len);
							return 1'b1;
						end
						phase             = PH_WREQ;
						r.chip_select     = 1'b1;
						r.payload_request = 1'b1;
						return 1'b1;
					end
					default: return 1'b0;
				endcase
			end
			OP_PAYLOAD: begin
				if (phase != PH_WREQ)
					return 1'b0;
				phase = PH_WSENT;
				emit(r, w.payload_byte);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic string show(input spi_hs_out_t r);
		return {$sformatf("cs=%0d sv=%0d sb=%h pr=%0d rv=%0d rb=%h",
				r.chip_select, r.send_valid, r.send_byte, r.payload_request,
				r.read_valid, r.read_byte),
			$sformatf(" done=%0d st=%0d dc=%h gl=%h",
				r.done_res, r.status, r.device_code, r.granted_length)};
	endfunction

	task automatic flag(input spi_hs_out_t e, input spi_hs_out_t a, input bit stray);
		if (failures < 10) begin
			if (stray)
				$display("%0t: result with none awaited: %s", $realtime, show(a));
			else begin
				$display("%0t: result mismatch, expected: %s", $realtime, show(e));
				$display("%0t: result mismatch, actual:   %s", $realtime, show(a));
			end
		end
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		spi_hs_out_t want;
		spi_hs_out_t made;
		if (!arst_n) begin
			wait_limit  = LIMIT_RESET;
			phase       = PH_IDLE;
			is_rd       = 1'b0;
			hdr_idx     = '0;
			req_len     = '0;
			grant_len   = '0;
			byte_cnt    = '0;
			miss_cnt    = '0;
			awaited_res.delete();
			outstanding = 0;
			failures    = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (awaited_res.size() == 0)
					flag(res, res, 1'b1);
				else begin
					want = awaited_res.pop_front();
					if (res !== want)
						flag(want, res, 1'b0);
				end
			end
			if (psel && penable && pwrite && pready && paddr == {REG_TIMEOUT, 2'b00})
				wait_limit = pwdata[LIMIT_W-1:0];
			if (item_valid && !item_stall && sequence_step(item, made))
				awaited_res.push_back(made);
			outstanding = awaited_res.size();
		end
	end

endmodule

/* dv/tb.sv */
// testbench top for the spi handshake transfer master: clock, reset, word and apb stimulus,
// stall generation and verdict; depends on spi_hs_pkg, the top level and spi_hs_xfer_checker
`timescale 1ns / 1ps

module tb;
	import spi_hs_pkg::*;

	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
	localparam int         WORDS_PER_PHASE = 362;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	spi_hs_in_t         item       = '0;
	logic               res_valid;
	logic               res_stall  = 1'b0;
	spi_hs_out_t        res;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [PADDR_W-1:0] paddr      = '0;
	logic [PDATA_W-1:0] pwdata     = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 failures;
	int                 outstanding;

	int idle_pct   = 0;
	int stall_pct  = 0;
	int noise_pct  = 0;
	int cur_limit  = int'(LIMIT_RESET);
	int words_sent = 0;

	int phase_idle[4]  = '{0, 85, 0, 11};
	int phase_stall[4] = '{0, 0, 85, 11};
	int phase_limit[4] = '{1, 100, 3, 1000000};

	spi_handshake_transfer_master_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	spi_hs_xfer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// every task below starts and ends on a falling edge
	task automatic put_word(input spi_hs_in_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic spi_hs_in_t any_word(input logic [2:0] op);
		logic [63:0] bits;
		spi_hs_in_t  w;
		bits = {$urandom, $urandom};
		w    = bits[$bits(spi_hs_in_t)-1:0];
		w.op = op;
		return w;
	endfunction

	// a byte the slave would never answer with as ack or good status
	function automatic logic [7:0] stray_rx();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		return (b == TAG_ACK) ? ~TAG_ACK : b;
	endfunction

	function automatic int pick_misses();
		if (cur_limit > 1000)
			return $urandom_range(0, 3);
		if ($urandom_range(0, cur_limit > 10 ? 59 : 7) == 0)
			return cur_limit + 2;
		return $urandom_range(0, (cur_limit + 1 < 3) ? cur_limit + 1 : 3);
	endfunction

	task automatic put_tick(input logic lvl);
		spi_hs_in_t w;
		w           = any_word(OP_TICK);
		w.dir_level = lvl;
		put_word(w);
	endtask

	task automatic put_rx(input logic [7:0] b);
		spi_hs_in_t w;
		w         = any_word(OP_SPI_BYTE);
		w.rx_byte = b;
		put_word(w);
	endtask

	task automatic hold_line(input logic lvl, input int misses, output bit failed);
		repeat (misses)
			put_tick(!lvl);
		failed = (misses >= cur_limit + 2);
		if (!failed)
			put_tick(lvl);
	endtask

	// words the sequencer ignores or answers busy, mixed into a running transfer
	task automatic chatter(input bit tick_ok);
		spi_hs_in_t w;
		if ($urandom_range(0, 99) >= noise_pct)
			return;
		case ($urandom_range(0, tick_ok ? 2 : 1))
			0: w = any_word($urandom_range(0, 1) ? OP_START_RD : OP_START_WR);
			1: w = any_word(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)));
			default: w = any_word(OP_TICK);
		endcase
		put_word(w);
	endtask

	task automatic run_transfer(input bit rd, input bit pend, input logic [15:0] len,
			input int m1, input int m2, input int m3, input logic [7:0] ack,
			input logic [7:0] stat, input logic [15:0] grant, input bit busy);
		spi_hs_in_t w;
		bit         failed;
		w              = any_word(rd ? OP_START_RD : OP_START_WR);
		w.length       = len;
		w.data_pending = pend;
		put_word(w);
		if (rd && !pend)
			return;
		if (busy)
			put_word(any_word(rd ? OP_START_WR : OP_START_RD));
		chatter(1'b0);
		hold_line(1'b1, m1, failed);
		if (failed)
			return;
		repeat (4) begin
			chatter(1'b1);
			put_rx(8'($urandom));
		end
		chatter(1'b0);
		hold_line(1'b0, m2, failed);
		if (failed)
			return;
		put_rx(ack);
		if (ack != TAG_ACK)
			return;
		chatter(1'b1);
		put_rx(stat);
		if (stat != 8'h00)
			return;
		put_rx(grant[15:8]);
		chatter(1'b1);
		put_rx(grant[7:0]);
		if (rd) begin
			repeat (int'(grant)) begin
				chatter(1'b1);
				put_rx(8'($urandom));
			end
			return;
		end
		chatter(1'b0);
		hold_line(1'b1, m3, failed);
		if (failed)
			return;
		repeat (int'(grant)) begin
			chatter(1'b1);
			put_word(any_word(OP_PAYLOAD));
			chatter(1'b1);
			put_rx(8'($urandom));
		end
	endtask

	// random words of any op, then a fixed walk that brings any half-begun transfer back to idle
	task automatic stray_burst();
		spi_hs_in_t w;
		repeat ($urandom_range(1, 6)) begin
			w = any_word(3'($urandom_range(OP_START_WR, OP_UNUSED_LAST)));
			if (w.op == OP_SPI_BYTE)
				w.rx_byte = stray_rx();
			put_word(w);
		end
		put_tick(1'b1);
		repeat (4)
			put_rx(stray_rx());
		put_tick(1'b0);
		put_rx(stray_rx());
	endtask

	task automatic random_round();
		logic [15:0] len;
		logic [15:0] grant;
		int          pick;
		if ($urandom_range(0, 99) < 6) begin
			stray_burst();
			return;
		end
		len  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8));
		pick = $urandom_range(0, 199);
		if (pick == 0)
			grant = 16'($urandom_range(256, 263));
		else if (pick < 20)
			grant = 16'h0000;
		else if (pick < 165)
			grant = 16'($urandom_range(1, 6));
		else
			grant = 16'($urandom_range(7, 40));
		run_transfer($urandom_range(0, 1) != 0, $urandom_range(0, 9) != 0, len,
			pick_misses(), pick_misses(), pick_misses(),
			$urandom_range(0, 9) ? TAG_ACK : stray_rx(),
			$urandom_range(0, 9) ? 8'h00 : stray_rx(),
			grant, $urandom_range(0, 19) == 0);
	endtask

	// hold the word channel until every result is in and the pipeline has emptied
	task automatic settle();
		item_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (6)
			@(negedge clk);
	endtask

	task automatic write_limit(input int v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_TIMEOUT, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_limit = v;
		@(negedge clk);
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_limit(0);
		put_word(any_word(OP_START_RD));
		put_tick(1'b1);
		put_rx(TAG_ACK);
		put_word(any_word(OP_PAYLOAD));
		put_word(any_word(OP_UNUSED_LAST));
		run_transfer(1'b0, 1'b1, 16'hFFFF, 2, 0, 0, TAG_ACK, 8'h00, 16'h0001, 1'b0);
		run_transfer(1'b1, 1'b1, 16'h0000, 0, 1, 0, TAG_ACK, 8'h00, 16'h0002, 1'b1);
		settle();

		noise_pct = 6;
		for (int p = 0; p < 4; p++) begin
			idle_pct   = phase_idle[p];
			stall_pct  = phase_stall[p];
			write_limit(phase_limit[p]);
			words_sent = 0;
			while (words_sent < WORDS_PER_PHASE) begin
				random_round();
				if ($urandom_range(0, 39) == 0)
					settle();
			end
			settle();
		end

		repeat (20)
			@(negedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
